// ----- sv/vl2n_pkg.sv -----
// Shared widths for the L2 vector normalizer.
package vl2n_pkg;
   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 38;
   localparam int ROOT_W   = SUM_W / 2;
   localparam int FRAC_W   = 15;
   localparam int DVD_W    = SAMPLE_W + FRAC_W;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic        [SUM_W-1:0]    sum_type;
   typedef logic        [ROOT_W-1:0]   root_type;
endpackage

// ----- sv/vector_l2_normalizer.sv -----
// Top level of the L2 vector normalizer with its element memory and sequencer.
// Requests are taken one per cycle while a vector is being collected; the
// vector closes on the marked last element or when MAX_ELEMENTS elements are
// held. The block then stops taking requests, computes the square root of
// the sum of squares (one root bit per cycle), and emits the stored elements
// in arrival order, each after a memory read and a restoring division. An
// all-zero vector yields zeros with rsp_zero_norm raised and skips the
// divisions.
module vector_l2_normalizer
   import vl2n_pkg::*;
#(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  sample_type  req_sample,
   input  logic        req_last_element,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output sample_type  rsp_normalized,
   output logic        rsp_last_result,
   output logic        rsp_zero_norm
);
   localparam int ADDR_W = $clog2(MAX_ELEMENTS);

   localparam logic [2:0] S_COLLECT   = 3'd0;
   localparam logic [2:0] S_ROOT_GO   = 3'd1;
   localparam logic [2:0] S_ROOT_WAIT = 3'd2;
   localparam logic [2:0] S_READ      = 3'd3;
   localparam logic [2:0] S_DIV_GO    = 3'd4;
   localparam logic [2:0] S_DIV_WAIT  = 3'd5;
   localparam logic [2:0] S_SEND      = 3'd6;

   sample_type          element_store [MAX_ELEMENTS];
   sample_type          rd_data_ff;

   logic [2:0]          state_ff, state_in;
   logic [ADDR_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]   last_idx_ff, last_idx_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   sum_type             sum_ff, sum_in;
   root_type            norm_ff, norm_in;
   sample_type          out_ff, out_in;
   logic                out_last_ff, out_last_in;
   logic                out_zero_ff, out_zero_in;

   logic                req_fire;
   logic signed [31:0]  square;
   logic [SUM_W:0]      sum_wide;
   logic                root_start, root_done, div_start, div_done;
   root_type            root;
   sample_type          quotient;

   assign req_fire = req_valid && req_ready;
   assign square   = 32'(req_sample) * 32'(req_sample);
   assign sum_wide = {1'b0, sum_ff} + (SUM_W+1)'($unsigned(square));

   assign root_start = (state_ff == S_ROOT_GO);
   assign div_start  = (state_ff == S_DIV_GO) && (norm_ff != '0);

   vl2n_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sum_ff),
      .done     (root_done),
      .root     (root)
   );

   vl2n_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sample   (rd_data_ff),
      .norm     (norm_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (req_fire) begin
         element_store[count_ff] <= req_sample;
      end
      rd_data_ff <= element_store[idx_ff];
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      last_idx_in = last_idx_ff;
      idx_in      = idx_ff;
      sum_in      = sum_ff;
      norm_in     = norm_ff;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      out_zero_in = out_zero_ff;
      unique case (state_ff)
         S_COLLECT: begin
            if (req_fire) begin
               sum_in   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
               count_in = count_ff + 1'b1;
               if (req_last_element || count_ff == ADDR_W'(MAX_ELEMENTS - 1)) begin
                  last_idx_in = count_ff;
                  idx_in      = '0;
                  state_in    = S_ROOT_GO;
               end
            end
         end
         S_ROOT_GO: begin
            state_in = S_ROOT_WAIT;
         end
         S_ROOT_WAIT: begin
            if (root_done) begin
               norm_in  = root;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            out_last_in = (idx_ff == last_idx_ff);
            if (norm_ff == '0) begin
               out_in      = '0;
               out_zero_in = 1'b1;
               state_in    = S_SEND;
            end else begin
               out_zero_in = 1'b0;
               state_in    = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               out_in   = quotient;
               state_in = S_SEND;
            end
         end
         S_SEND: begin
            if (rsp_ready) begin
               if (idx_ff == last_idx_ff) begin
                  sum_in   = '0;
                  count_in = '0;
                  state_in = S_COLLECT;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_COLLECT;
         count_ff <= '0;
         sum_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         idx_ff   <= idx_in;
      end
      last_idx_ff <= last_idx_in;
      norm_ff     <= norm_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      out_zero_ff <= out_zero_in;
   end

   assign req_ready       = (state_ff == S_COLLECT);
   assign rsp_valid       = (state_ff == S_SEND);
   assign rsp_normalized  = out_ff;
   assign rsp_last_result = out_last_ff;
   assign rsp_zero_norm   = out_zero_ff;
endmodule

// ----- sv/vl2n_sqrt.sv -----
// Iterative integer square root, one root bit per cycle.
module vl2n_sqrt
   import vl2n_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  sum_type  radicand,
   output logic     done,
   output root_type root
);
   localparam int CNT_W = $clog2(ROOT_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   sum_type           rad_ff, rad_in;
   logic [ROOT_W:0]   rem_ff, rem_in;
   root_type          root_ff, root_in;
   logic [ROOT_W+2:0] rem_sh;
   logic [ROOT_W+2:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      rem_sh  = {rem_ff, rad_ff[SUM_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SUM_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = (ROOT_W+1)'(rem_sh - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = (ROOT_W+1)'(rem_sh);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// ----- sv/vl2n_div.sv -----
// Restoring divider for one element over the norm, with sign and saturation.
module vl2n_div
   import vl2n_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  sample_type sample,
   input  root_type   norm,
   output logic       done,
   output sample_type quotient
);
   localparam int CNT_W = $clog2(DVD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   root_type          dvs_ff, dvs_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DVD_W-1:0]  q_ff, q_in;
   root_type          rem_ff, rem_in;
   logic [ROOT_W:0]   rem_sh;
   logic [SAMPLE_W-1:0] mag;
   logic [SAMPLE_W-1:0] sat;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      dvs_in  = dvs_ff;
      dvd_in  = dvd_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      mag     = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);
      rem_sh  = {rem_ff, dvd_ff[DVD_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = sample[SAMPLE_W-1];
         dvs_in  = norm;
         dvd_in  = {mag, FRAC_W'(0)};
         q_in    = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = ROOT_W'(rem_sh - {1'b0, dvs_ff});
            q_in   = {q_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = ROOT_W'(rem_sh);
            q_in   = {q_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      if (neg_ff) begin
         if (q_ff > DVD_W'(32768)) begin
            sat = 16'h8000;
         end else begin
            sat = SAMPLE_W'(-q_ff);
         end
      end else begin
         if (q_ff > DVD_W'(32767)) begin
            sat = 16'h7fff;
         end else begin
            sat = SAMPLE_W'(q_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      dvs_ff <= dvs_in;
      dvd_ff <= dvd_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = sample_type'(sat);
endmodule
